@@ rtl/galb_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and constants of the greedy affinity load balancer
package galb_pkg;

	localparam int MAX_PROCS_DEF   = 64;
	localparam int NODE_GROUPS_DEF = 4;

	localparam logic [15:0] SPEED_ONE = 16'd4096;
	localparam logic [39:0] LOAD_MAX  = 40'hFF_FFFF_FFFF;
	localparam logic [45:0] SUM_MAX   = 46'h3FFF_FFFF_FFFF;
	localparam logic [15:0] MCNT_MAX  = 16'hFFFF;
	localparam logic [5:0]  DIV_LAST  = 6'd47;

	typedef enum logic [1:0] {
		CMD_SET    = 2'd0,
		CMD_PIN    = 2'd1,
		CMD_PLACE  = 2'd2,
		CMD_REPORT = 2'd3
	} cmd_e_t;

	typedef enum logic [1:0] {
		ERR_OK     = 2'd0,
		ERR_PIN    = 2'd1,
		ERR_NOPROC = 2'd2,
		ERR_RSVD   = 2'd3
	} err_e_t;

	typedef enum logic [1:0] {
		CFG_PPN  = 2'd0,
		CFG_NEAR = 2'd1,
		CFG_FAR  = 2'd2,
		CFG_NONE = 2'd3
	} cfg_e_t;

	typedef struct packed {
		logic        avail;
		logic [15:0] speed;
		logic [39:0] load;
	} slot_t;

	// controller to datapath
	typedef struct packed {
		logic clr_wr;
		logic load_in;
		logic set_wr;
		logic pin_wr;
		logic hg_step;
		logic scan_start;
		logic scan_step;
		logic mul;
		logic div_init;
		logic div_step;
		logic upd;
		logic out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic hg_hit;
		logic scan_end;
		logic found;
		logic is_place;
		logic div_last;
		logic out_busy;
	} dp_sts_t;

	function automatic logic [39:0] sat_load(input logic [48:0] s);
		logic [39:0] r;
		r = (s > 49'(LOAD_MAX)) ? LOAD_MAX : s[39:0];
		return r;
	endfunction

endpackage

@@ rtl/galb_ctrl.sv @@
`timescale 1ns / 1ps
// controller state machine of the greedy affinity load balancer
module galb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         command,
	output logic               in_stall,
	input  galb_pkg::dp_sts_t  sts,
	output galb_pkg::dp_cmd_t  cmd
);

	typedef enum logic [10:0] {
		ST_CLR   = 11'b000_0000_0001,
		ST_IDLE  = 11'b000_0000_0010,
		ST_SETW  = 11'b000_0000_0100,
		ST_PIN   = 11'b000_0000_1000,
		ST_HGRP  = 11'b000_0001_0000,
		ST_SCAN  = 11'b000_0010_0000,
		ST_MUL   = 11'b000_0100_0000,
		ST_DINIT = 11'b000_1000_0000,
		ST_DIV   = 11'b001_0000_0000,
		ST_UPD   = 11'b010_0000_0000,
		ST_FIN   = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					case (command)
						galb_pkg::CMD_SET:   state_d = ST_SETW;
						galb_pkg::CMD_PIN:   state_d = ST_PIN;
						galb_pkg::CMD_PLACE: state_d = ST_HGRP;
						default:             state_d = ST_SCAN;
					endcase
				end
			end
			ST_SETW: begin
				cmd.set_wr = 1'b1;
				state_d    = ST_FIN;
			end
			ST_PIN: begin
				cmd.pin_wr = 1'b1;
				state_d    = ST_FIN;
			end
			ST_HGRP: begin
				cmd.hg_step = 1'b1;
				if (sts.hg_hit) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_end)
					state_d = (sts.is_place && sts.found) ? ST_MUL : ST_FIN;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLR;
		else         state_q <= state_d;
	end

endmodule

@@ rtl/galb_dp.sv @@
`timescale 1ns / 1ps
// datapath: slot table memory, scan compare, multiply and serial divide
module galb_dp #(
	parameter int MAX_PROCS   = galb_pkg::MAX_PROCS_DEF,
	parameter int NODE_GROUPS = galb_pkg::NODE_GROUPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic [1:0]         command,
	input  logic [5:0]         proc_index,
	input  logic               proc_available,
	input  logic [31:0]        background_load,
	input  logic [31:0]        overhead_load,
	input  logic [15:0]        proc_speed,
	input  logic [15:0]        object_id,
	input  logic [31:0]        object_time,
	input  galb_pkg::dp_cmd_t  cmd,
	output galb_pkg::dp_sts_t  sts,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [5:0]         dest_proc,
	output logic               moved,
	output logic [15:0]        placed_id,
	output logic [1:0]         error_code,
	output logic [15:0]        move_total,
	output logic [39:0]        peak_load,
	output logic [45:0]        sum_load
);

	localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CW = (AW + 1 > 7) ? AW + 1 : 7;
	localparam int GW = (NODE_GROUPS > 1) ? $clog2(NODE_GROUPS) : 1;
	localparam logic [CW-1:0] PROCS_C = CW'(MAX_PROCS);
	localparam logic [GW-1:0] GRP_LAST = GW'(NODE_GROUPS - 1);

	// configuration
	logic [6:0] ppn_q;
	logic [7:0] near_q, far_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppn_q  <= 7'd1;
			near_q <= 8'd1;
			far_q  <= 8'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				galb_pkg::CFG_PPN:  ppn_q  <= cfg_data[6:0];
				galb_pkg::CFG_NEAR: near_q <= cfg_data;
				galb_pkg::CFG_FAR:  far_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured beat
	galb_pkg::cmd_e_t cmd_q;
	logic [5:0]  idx_q;
	logic        avail_q;
	logic [31:0] bg_q, ov_q, t_q;
	logic [15:0] spd_q, id_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q   <= galb_pkg::cmd_e_t'(command);
			idx_q   <= proc_index;
			avail_q <= proc_available;
			bg_q    <= background_load;
			ov_q    <= overhead_load;
			spd_q   <= proc_speed;
			id_q    <= object_id;
			t_q     <= object_time;
		end
	end

	logic in_range;
	assign in_range = CW'(idx_q) < PROCS_C;

	// slot table
	galb_pkg::slot_t mem_q [MAX_PROCS];
	galb_pkg::slot_t rd_q, wr_data;
	logic            wr_en;
	logic [AW-1:0]   wr_addr, rd_addr;

	logic [CW-1:0] ctr_q;
	logic [6:0]    sub_q;
	logic [GW-1:0] grp_q, hgrp_q;
	logic [15:0]   hspd_q;
	logic [AW-1:0] bidx_q;
	logic [47:0]   prod_q;

	always_comb begin
		if (cmd.scan_step)
			rd_addr = ctr_q[AW-1:0];
		else if (cmd.mul || cmd.div_init || cmd.div_step || cmd.upd)
			rd_addr = bidx_q;
		else if (cmd.hg_step)
			rd_addr = AW'(idx_q);
		else
			rd_addr = AW'(proc_index);
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = AW'(idx_q);
		wr_data = rd_q;
		if (cmd.clr_wr) begin
			wr_en   = 1'b1;
			wr_addr = ctr_q[AW-1:0];
			wr_data = '{avail: 1'b0, speed: galb_pkg::SPEED_ONE, load: 40'd0};
		end else if (cmd.set_wr) begin
			wr_en   = in_range;
			wr_data = '{avail: avail_q,
			            speed: (spd_q == 16'd0) ? 16'd1 : spd_q,
			            load:  40'({1'b0, bg_q} + {1'b0, ov_q})};
		end else if (cmd.pin_wr) begin
			wr_en        = in_range && rd_q.avail;
			wr_data.load = galb_pkg::sat_load(49'(rd_q.load) + 49'(t_q));
		end else if (cmd.upd) begin
			wr_en        = 1'b1;
			wr_addr      = bidx_q;
			wr_data.load = galb_pkg::sat_load(49'(rd_q.load) + 49'(prod_q));
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_q <= mem_q[rd_addr];
	end

	// index counter with node group tracking
	logic [6:0] ppn_eff;
	logic       sub_wrap, hg_hit, issue;
	assign ppn_eff  = (ppn_q == 7'd0) ? 7'd1 : ppn_q;
	assign sub_wrap = (sub_q == ppn_eff - 7'd1);
	assign hg_hit   = (ctr_q == CW'(idx_q));
	assign issue    = cmd.scan_step && (ctr_q < PROCS_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
			sub_q <= '0;
			grp_q <= '0;
		end else if (cmd.clr_wr) begin
			ctr_q <= (ctr_q[AW-1:0] == AW'(MAX_PROCS - 1)) ? '0 : ctr_q + 1'b1;
		end else if (cmd.load_in || cmd.scan_start) begin
			ctr_q <= '0;
			sub_q <= '0;
			grp_q <= '0;
		end else if ((cmd.hg_step && !hg_hit) || issue) begin
			ctr_q <= ctr_q + 1'b1;
			if (sub_wrap) begin
				sub_q <= '0;
				grp_q <= (grp_q == GRP_LAST) ? '0 : grp_q + 1'b1;
			end else begin
				sub_q <= sub_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hg_step) begin
			hspd_q <= in_range ? rd_q.speed : galb_pkg::SPEED_ONE;
			if (hg_hit) hgrp_q <= grp_q;
		end
	end

	// scan stage one, lined up with the registered read
	logic          vld_s1;
	logic [AW-1:0] idx_s1;
	logic [GW-1:0] grp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= issue;
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ctr_q[AW-1:0];
		grp_s1 <= grp_q;
	end

	// compare and accumulate
	logic [24:0] best_q, cost;
	logic [7:0]  pen;
	logic        found_q;
	logic [39:0] maxl_q;
	logic [45:0] suml_q;
	logic [46:0] sum_c;

	assign pen   = (grp_s1 == hgrp_q) ? near_q : far_q;
	assign cost  = {1'b0, rd_q.load[39:16]} + 25'(pen);
	assign sum_c = {1'b0, suml_q} + 47'(rd_q.load);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.load_in) begin
			found_q <= 1'b0;
		end else if (vld_s1 && rd_q.avail && cmd_q == galb_pkg::CMD_PLACE) begin
			if (!found_q || cost < best_q) found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			maxl_q <= '0;
			suml_q <= '0;
		end else if (vld_s1 && rd_q.avail) begin
			if (cmd_q == galb_pkg::CMD_PLACE) begin
				if (!found_q || cost < best_q) begin
					best_q <= cost;
					bidx_q <= idx_s1;
				end
			end else begin
				if (rd_q.load > maxl_q) maxl_q <= rd_q.load;
				suml_q <= (sum_c > 47'(galb_pkg::SUM_MAX)) ? galb_pkg::SUM_MAX :
				          sum_c[45:0];
			end
		end
	end

	// scaled load and restoring divide, one quotient bit a cycle
	logic [15:0] rem_q, dvs_q;
	logic [5:0]  dcnt_q;
	logic [16:0] trial;
	logic        ge;
	logic [47:0] prod_c;

	assign prod_c = t_q * hspd_q;
	assign trial  = {rem_q, prod_q[47]};
	assign ge     = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= prod_c;
		end else if (cmd.div_init) begin
			dvs_q  <= rd_q.speed;
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= ge ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
			prod_q <= {prod_q[46:0], ge};
			dcnt_q <= dcnt_q + 6'd1;
		end
	end

	// move bookkeeping
	logic        moved_q, pin_err_q, moved_c;
	logic [15:0] mcnt_q;
	assign moved_c = (CW'(bidx_q) != CW'(idx_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moved_q   <= 1'b0;
			pin_err_q <= 1'b0;
			mcnt_q    <= '0;
		end else if (cmd.load_in) begin
			moved_q   <= 1'b0;
			pin_err_q <= 1'b0;
		end else if (cmd.pin_wr) begin
			pin_err_q <= !(in_range && rd_q.avail);
		end else if (cmd.upd) begin
			moved_q <= moved_c;
			if (moved_c && mcnt_q != galb_pkg::MCNT_MAX) mcnt_q <= mcnt_q + 16'd1;
		end
	end

	// output register
	logic is_place, is_rep;
	assign is_place = (cmd_q == galb_pkg::CMD_PLACE);
	assign is_rep   = (cmd_q == galb_pkg::CMD_REPORT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                     out_valid <= 1'b0;
		else if (cmd.out_load)           out_valid <= 1'b1;
		else if (out_valid && !out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			dest_proc  <= (is_place && found_q) ? 6'(bidx_q) : 6'd0;
			moved      <= moved_q;
			placed_id  <= is_place ? id_q : 16'd0;
			move_total <= mcnt_q;
			peak_load  <= is_rep ? maxl_q : 40'd0;
			sum_load   <= is_rep ? suml_q : 46'd0;
			case (cmd_q)
				galb_pkg::CMD_PIN:
					error_code <= pin_err_q ? galb_pkg::ERR_PIN : galb_pkg::ERR_OK;
				galb_pkg::CMD_PLACE:
					error_code <= found_q ? galb_pkg::ERR_OK : galb_pkg::ERR_NOPROC;
				default:
					error_code <= galb_pkg::ERR_OK;
			endcase
		end
	end

	assign sts.clr_last = (ctr_q[AW-1:0] == AW'(MAX_PROCS - 1));
	assign sts.hg_hit   = hg_hit;
	assign sts.scan_end = (ctr_q == PROCS_C) && !vld_s1;
	assign sts.found    = found_q;
	assign sts.is_place = is_place;
	assign sts.div_last = (dcnt_q == galb_pkg::DIV_LAST);
	assign sts.out_busy = out_valid && out_stall;

`ifndef ASSERT_OFF
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rem_q < dvs_q)
		else $error("divider remainder not below divisor");
	a_mcnt_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		mcnt_q != $past(mcnt_q) |-> mcnt_q == $past(mcnt_q) + 16'd1)
		else $error("move count jumped");
	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> CW'(idx_s1) < PROCS_C)
		else $error("scan compare outside slot table");
	a_upd_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |-> found_q)
		else $error("placement update without a chosen slot");
`endif

endmodule

@@ rtl/greedy_affinity_load_balancer_top.sv @@
`timescale 1ns / 1ps
// top level: greedy affinity load balancer, controller plus datapath
// one command at a time, through the slot scan and the 48-step divider; the next beat is
//   taken while a finished result waits to be taken
// reset: clearing pass over every slot of the slot table, no beat taken; config and moves
//   to default
module greedy_affinity_load_balancer_top #(
	parameter int MAX_PROCS   = galb_pkg::MAX_PROCS_DEF,
	parameter int NODE_GROUPS = galb_pkg::NODE_GROUPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// command beat
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [5:0]  proc_index,
	input  logic        proc_available,
	input  logic [31:0] background_load,
	input  logic [31:0] overhead_load,
	input  logic [15:0] proc_speed,
	input  logic [15:0] object_id,
	input  logic [31:0] object_time,
	// result beat
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  dest_proc,
	output logic        moved,
	output logic [15:0] placed_id,
	output logic [1:0]  error_code,
	output logic [15:0] move_total,
	output logic [39:0] peak_load,
	output logic [45:0] sum_load
);

	// command and status between sequencer and datapath
	galb_pkg::dp_cmd_t cmd;
	galb_pkg::dp_sts_t sts;

	// sequencer: clearing pass, command dispatch, scan, divide, result
	galb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// slot table, cost compare, load scaling and output register
	galb_dp #(
		.MAX_PROCS   (MAX_PROCS),
		.NODE_GROUPS (NODE_GROUPS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.command         (command),
		.proc_index      (proc_index),
		.proc_available  (proc_available),
		.background_load (background_load),
		.overhead_load   (overhead_load),
		.proc_speed      (proc_speed),
		.object_id       (object_id),
		.object_time     (object_time),
		.cmd             (cmd),
		.sts             (sts),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.dest_proc       (dest_proc),
		.moved           (moved),
		.placed_id       (placed_id),
		.error_code      (error_code),
		.move_total      (move_total),
		.peak_load       (peak_load),
		.sum_load        (sum_load)
	);

endmodule

@@ test/greedy_affinity_load_balancer_checker.sv @@
`timescale 1ns / 1ps
// checker: predicts every result beat of the load balancer and compares it
module greedy_affinity_load_balancer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  command,
	input  logic [5:0]  proc_index,
	input  logic        proc_available,
	input  logic [31:0] background_load,
	input  logic [31:0] overhead_load,
	input  logic [15:0] proc_speed,
	input  logic [15:0] object_id,
	input  logic [31:0] object_time,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [5:0]  dest_proc,
	input  logic        moved,
	input  logic [15:0] placed_id,
	input  logic [1:0]  error_code,
	input  logic [15:0] move_total,
	input  logic [39:0] peak_load,
	input  logic [45:0] sum_load,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [5:0]  dest;
		logic        mv;
		logic [15:0] pid;
		logic [1:0]  err;
		logic [15:0] mtot;
		logic [39:0] maxl;
		logic [45:0] suml;
	} verdict_t;

	verdict_t    expected_q[$];
	logic [39:0] load_tbl[64];
	logic [15:0] speed_tbl[64];
	logic        avail_tbl[64];
	logic [15:0] move_cnt;
	logic [6:0]  ppn;
	logic [7:0]  near_pen, far_pen;

	function automatic logic [1:0] group_of(input int idx);
		int p;
		p = (ppn == 0) ? 1 : int'(ppn);
		return 2'((idx / p) % 4);
	endfunction

	function automatic logic [39:0] add_sat(input logic [39:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = 65'(a) + 65'(b);
		return (s > 65'(galb_pkg::LOAD_MAX)) ? galb_pkg::LOAD_MAX : s[39:0];
	endfunction

	// one command against the mirrored slot table
	task automatic balance_step(output verdict_t v);
		logic [63:0] cost, best_cost, delta, sum;
		logic [1:0]  home_grp;
		int          best;
		bit          found;
		v = '0;
		case (galb_pkg::cmd_e_t'(command))
			galb_pkg::CMD_SET: begin
				avail_tbl[proc_index] = proc_available;
				speed_tbl[proc_index] = (proc_speed == 0) ? 16'd1 : proc_speed;
				load_tbl[proc_index]  = add_sat(40'(background_load), 64'(overhead_load));
			end
			galb_pkg::CMD_PIN: begin
				if (avail_tbl[proc_index])
					load_tbl[proc_index] = add_sat(load_tbl[proc_index], 64'(object_time));
				else
					v.err = galb_pkg::ERR_PIN;
			end
			galb_pkg::CMD_PLACE: begin
				v.pid = object_id;
				home_grp = group_of(proc_index);
				best_cost = 64'd100000000;
				found = 0;
				best = 0;
				for (int i = 0; i < 64; i++) begin
					if (!avail_tbl[i]) continue;
					cost = 64'(load_tbl[i] >> 16) +
						((group_of(i) == home_grp) ? 64'(near_pen) : 64'(far_pen));
					if (cost < best_cost) begin
						best_cost = cost;
						best = i;
						found = 1;
					end
				end
				if (!found) v.err = galb_pkg::ERR_NOPROC;
				else begin
					delta = (64'(object_time) * 64'(speed_tbl[proc_index])) /
						64'(speed_tbl[best]);
					load_tbl[best] = add_sat(load_tbl[best], delta);
					v.dest = 6'(best);
					if (best != int'(proc_index)) begin
						v.mv = 1;
						if (move_cnt != galb_pkg::MCNT_MAX) move_cnt++;
					end
				end
			end
			default: begin
				sum = 0;
				for (int i = 0; i < 64; i++) begin
					if (!avail_tbl[i]) continue;
					if (load_tbl[i] > v.maxl) v.maxl = load_tbl[i];
					sum += 64'(load_tbl[i]);
					if (sum > 64'(galb_pkg::SUM_MAX)) sum = 64'(galb_pkg::SUM_MAX);
				end
				v.suml = sum[45:0];
			end
		endcase
		v.mtot = move_cnt;
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t v, e;
		if (!arst_n) begin
			for (int i = 0; i < 64; i++) begin
				load_tbl[i] = '0;
				speed_tbl[i] = galb_pkg::SPEED_ONE;
				avail_tbl[i] = 0;
			end
			move_cnt = '0;
			ppn = 7'd1;
			near_pen = 8'd1;
			far_pen = 8'd2;
			fail_count = 0;
			expected_q.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				v = {dest_proc, moved, placed_id, error_code, move_total, peak_load, sum_load};
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result beat %h", v);
				end else begin
					e = expected_q.pop_front();
					if (v !== e) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: dest %0d/%0d moved %0d/%0d id %h/%h",
								" err %0d/%0d mtot %0d/%0d max %h/%h sum %h/%h"},
								e.dest, dest_proc, e.mv, moved, e.pid, placed_id, e.err,
								error_code, e.mtot, move_total, e.maxl, peak_load,
								e.suml, sum_load);
					end
				end
			end
			if (in_valid && !in_stall) begin
				balance_step(v);
				expected_q.insert(expected_q.size(), v);
			end
			pending = expected_q.size();
			if (cfg_we) begin
				case (galb_pkg::cfg_e_t'(cfg_index))
					galb_pkg::CFG_PPN:  ppn = cfg_data[6:0];
					galb_pkg::CFG_NEAR: near_pen = cfg_data;
					galb_pkg::CFG_FAR:  far_pen = cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

@@ test/greedy_affinity_load_balancer_top_tb.sv @@
`timescale 1ns / 1ps
// testbench top: stimulus, configuration phases and verdict for the load balancer
module greedy_affinity_load_balancer_top_tb;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = galb_pkg::CFG_PPN;
	logic [7:0]  cfg_data = '0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  command = galb_pkg::CMD_REPORT;
	logic [5:0]  proc_index = '0;
	logic        proc_available = 0;
	logic [31:0] background_load = '0;
	logic [31:0] overhead_load = '0;
	logic [15:0] proc_speed = '0;
	logic [15:0] object_id = '0;
	logic [31:0] object_time = '0;
	logic        out_valid;
	logic        out_stall = 1;
	logic [5:0]  dest_proc;
	logic        moved;
	logic [15:0] placed_id;
	logic [1:0]  error_code;
	logic [15:0] move_total;
	logic [39:0] peak_load;
	logic [45:0] sum_load;
	int          fail_count;
	int          pending;
	int          idle_cycles;
	bit          timed_out;

	localparam int WATCHDOG_LIMIT = 4000;

	always #10 clk = ~clk;

	greedy_affinity_load_balancer_top i_dut (.*);

	greedy_affinity_load_balancer_checker i_checker (.*);

	// receiver stall pattern: each cycle picks no stall, a one-in-four stall or a one-in-two stall
	always @(posedge clk) begin
		int mode;
		mode = $urandom_range(0, 99);
		if (mode < 40) out_stall <= 0;
		else if (mode < 70) out_stall <= ($urandom_range(0, 3) == 0);
		else out_stall <= ($urandom_range(0, 1) == 0);
	end

	// watchdog: cycles with no beat in either direction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("** greedy_affinity_load_balancer_top: FAILED **");
			$finish;
		end
	end

	// drive one beat and hold it until accepted
	task automatic send_beat(input galb_pkg::cmd_e_t c, input logic [5:0] idx, input logic av,
		input logic [31:0] bg, input logic [31:0] ov, input logic [15:0] sp,
		input logic [15:0] id, input logic [31:0] t);
		in_valid <= 1;
		command <= c;
		proc_index <= idx;
		proc_available <= av;
		background_load <= bg;
		overhead_load <= ov;
		proc_speed <= sp;
		object_id <= id;
		object_time <= t;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic pause_sender(input int n);
		in_valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	// config writes only once the block has drained
	task automatic drain_and_configure(input logic [7:0] ppn, input logic [7:0] nearp,
		input logic [7:0] farp);
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		cfg_we <= 1;
		cfg_index <= galb_pkg::CFG_PPN;
		cfg_data <= ppn;
		@(posedge clk);
		cfg_index <= galb_pkg::CFG_NEAR;
		cfg_data <= nearp;
		@(posedge clk);
		cfg_index <= galb_pkg::CFG_FAR;
		cfg_data <= farp;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// random beat, mostly descending placements, with sets (mostly of available slots), pins and reports
	task automatic random_beat(inout logic [31:0] obj_time);
		int pick;
		logic [31:0] w;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			send_beat(galb_pkg::CMD_SET, 6'($urandom), ($urandom_range(0, 4) != 0),
				($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h0100_0000),
				($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000),
				($urandom_range(0, 19) == 0) ? 16'(0) :
				($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1024, 16384)),
				16'($urandom), $urandom);
		else if (pick < 25)
			send_beat(galb_pkg::CMD_PIN, 6'($urandom), 1'($urandom), $urandom, $urandom,
				16'($urandom), 16'($urandom),
				($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000));
		else if (pick < 90) begin
			// heaviest first, restart the ladder now and then
			if (obj_time < 32'h100 || $urandom_range(0, 29) == 0)
				obj_time = ($urandom_range(0, 7) == 0) ? $urandom :
					$urandom_range(0, 32'h0080_0000);
			w = obj_time;
			obj_time = obj_time - (obj_time >> 4) - 1;
			send_beat(galb_pkg::CMD_PLACE, 6'($urandom), 1'($urandom), $urandom, $urandom,
				16'($urandom), 16'($urandom), w);
		end else
			send_beat(galb_pkg::CMD_REPORT, 6'($urandom), 1'($urandom), $urandom, $urandom,
				16'($urandom), 16'($urandom), $urandom);
	endtask

	initial begin
		logic [31:0] ladder;
		timed_out = 0;
		ladder = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty table cases first
		send_beat(galb_pkg::CMD_PLACE, 6'd0, 0, 0, 0, 0, 16'hFFFF, 32'hFFFF_FFFF);
		send_beat(galb_pkg::CMD_PIN, 6'd63, 0, 0, 0, 0, 0, 32'd5);
		send_beat(galb_pkg::CMD_REPORT, 6'd0, 0, 0, 0, 0, 0, 0);
		// zero speed and extremes of load on set, then pins, placements and a report
		send_beat(galb_pkg::CMD_SET, 6'd0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 0, 0);
		send_beat(galb_pkg::CMD_SET, 6'd63, 1, 32'h0, 32'h0, 16'hFFFF, 0, 0);
		send_beat(galb_pkg::CMD_SET, 6'd5, 1, 32'h0001_0000, 32'h0, 16'd4096, 0, 0);
		send_beat(galb_pkg::CMD_SET, 6'd6, 0, 32'h0, 32'h0, 16'd1, 0, 0);
		send_beat(galb_pkg::CMD_PIN, 6'd6, 1, 0, 0, 0, 0, 32'd7);
		send_beat(galb_pkg::CMD_PIN, 6'd0, 1, 0, 0, 0, 0, 32'hFFFF_FFFF);
		send_beat(galb_pkg::CMD_PLACE, 6'd63, 0, 0, 0, 0, 16'h0001, 32'hFFFF_FFFF);
		send_beat(galb_pkg::CMD_PLACE, 6'd5, 0, 0, 0, 0, 16'h8000, 32'h0);
		send_beat(galb_pkg::CMD_PLACE, 6'd6, 0, 0, 0, 0, 16'h1234, 32'h0002_0000);
		send_beat(galb_pkg::CMD_REPORT, 6'd63, 1, 0, 0, 0, 0, 0);
		drain_and_configure(8'd0, 8'd0, 8'd255);
		send_beat(galb_pkg::CMD_PLACE, 6'd40, 0, 0, 0, 0, 16'h00AA, 32'h0001_0000);
		send_beat(galb_pkg::CMD_PLACE, 6'd0, 0, 0, 0, 0, 16'h0055, 32'h0000_8000);
		drain_and_configure(8'd127, 8'd255, 8'd0);
		send_beat(galb_pkg::CMD_PLACE, 6'd2, 0, 0, 0, 0, 16'h0102, 32'h0000_4000);
		send_beat(galb_pkg::CMD_REPORT, 6'd0, 0, 0, 0, 0, 0, 0);

		// random phases through several register settings
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: drain_and_configure(8'd1, 8'd1, 8'd2);
				1: drain_and_configure(8'd64, 8'd0, 8'd255);
				2: drain_and_configure(8'd4, 8'd255, 8'd0);
				3: drain_and_configure(8'd0, 8'd255, 8'd255);
				default: drain_and_configure(8'($urandom_range(1, 64)),
					8'($urandom), 8'($urandom));
			endcase
			for (int n = 0; n < 230; n++) begin
				random_beat(ladder);
				if ($urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 200));
				if (n == 100) begin
					// hold off until everything in flight has come back
					in_valid <= 0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
			end
		end

		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (250) @(posedge clk);
		if (fail_count == 0)
			$display("** greedy_affinity_load_balancer_top: PASSED **");
		else
			$display("** greedy_affinity_load_balancer_top: FAILED **");
		$finish;
	end

endmodule
